### design/esc_command_byte_parser_unit_defines.svh
// Assertion helpers used by the parser RTL.
`ifndef ESC_COMMAND_BYTE_PARSER_UNIT_DEFINES_SVH
`define ESC_COMMAND_BYTE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define ESCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escp: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define ESCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escp: next-cycle check failed");

`endif

### design/escp_pkg.sv
`default_nettype none
package escp_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned ACC_W = 10;
  localparam int unsigned PROD_W = 14;  // 1023 * 10 + 9 fits
  localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;
  localparam logic signed [8:0] WG_ALL = -9'sd1;

  // register word index (byte address / 4)
  localparam logic [0:0] REG_NUM_WG = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DIGITS   = 2'd1,
    ST_CMD_WAIT = 2'd2,
    ST_CMD_BODY = 2'd3
  } escp_state_t;

  typedef struct packed {
    escp_state_t       state;
    logic [ACC_W-1:0]  acc;
    logic signed [8:0] workgroup;
    logic [7:0]        first_byte;
  } escp_ctx_t;

  typedef struct packed {
    logic              part_of_command;
    logic              command_done;
    logic [7:0]        command_byte;
    logic signed [8:0] target_workgroup;
  } escp_res_t;

endpackage
`default_nettype wire

### design/escp_step.sv
`default_nettype none
// One byte through the parser: next context and the result for that byte.
module escp_step import escp_pkg::*; (
  input  wire escp_ctx_t  ctx,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] num_workgroups,
  output escp_ctx_t       ctx_next,
  output escp_res_t       res
);

  logic              is_esc;
  logic              is_comma;
  logic              is_digit;
  logic [3:0]        digit;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_sat;
  logic              wg_ok;

  assign is_esc   = (byte_in == CH_ESC);
  assign is_comma = (byte_in == CH_COMMA);
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign digit    = 4'(byte_in - CH_ZERO);

  // acc * 10 as two shifts, then saturate
  assign prod    = PROD_W'({ctx.acc, 3'b000}) + PROD_W'({ctx.acc, 1'b0}) + PROD_W'(digit);
  assign acc_sat = (prod > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
  assign wg_ok   = (ctx.acc < {2'b00, num_workgroups});

  always_comb begin
    ctx_next = ctx;
    res      = '0;
    unique case (ctx.state)
      ST_IDLE: begin
        if (is_esc) begin
          ctx_next.workgroup = WG_ALL;
          ctx_next.state     = ST_CMD_WAIT;
        end else if (is_digit) begin
          ctx_next.acc       = ACC_W'(digit);
          ctx_next.state     = ST_DIGITS;
          res.part_of_command = 1'b1;
        end
      end
      ST_DIGITS: begin
        res.part_of_command = 1'b1;
        if (is_esc) begin
          if (wg_ok) begin
            ctx_next.workgroup = $signed(ctx.acc[8:0]);
            ctx_next.state     = ST_CMD_WAIT;
          end else begin
            ctx_next.state = ST_IDLE;
          end
        end else if (is_digit) begin
          ctx_next.acc = acc_sat;
        end else begin
          ctx_next.state = ST_IDLE;
        end
      end
      ST_CMD_WAIT: begin
        res.part_of_command = 1'b1;
        if (!is_comma && !is_esc) begin
          ctx_next.first_byte = byte_in;
          ctx_next.state      = ST_CMD_BODY;
        end else begin
          ctx_next.state = ST_IDLE;
        end
      end
      ST_CMD_BODY: begin
        res.part_of_command = 1'b1;
        if (is_comma || is_esc) begin
          res.command_done     = 1'b1;
          res.command_byte     = ctx.first_byte;
          res.target_workgroup = ctx.workgroup;
          ctx_next.state       = is_comma ? ST_IDLE : ST_CMD_WAIT;
        end
      end
      default: ctx_next = ctx;
    endcase
  end

endmodule
`default_nettype wire

### design/esc_command_byte_parser_unit.sv
`default_nettype none
// Escape-command byte parser.
// Input channel: byte_valid / byte_ready with byte_in, one received byte per
//   transaction. Output channel: result_valid / result_ready with
//   part_of_command, command_done, command_byte and target_workgroup; exactly
//   one result transaction per input byte, in order.
// Pipeline: a byte that is taken sits in the input register; it is parsed and
//   its result is loaded into the result register when the input register moves on.
// Throughput: one byte per cycle while results are taken, set by the single
//   parser step between the input and result registers; the parser context
//   is updated in that step, so back-to-back bytes see each other's effect.
// Stall: while result_ready is low the result register holds; an empty
//   input register still takes one more byte, then byte_ready stays low
//   until the result is taken (it rises in that same cycle).
// Reset (rst, synchronous): both stages empty, parser idle with workgroup -1
//   (all), num_workgroups = 1.
// APB port: num_workgroups at byte address 0; write only while the block
//   is idle. pready is tied high.
module esc_command_byte_parser_unit
  import escp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // byte input
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire logic [7:0]        byte_in,
  // result output
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic                   part_of_command,
  output logic                   command_done,
  output logic [7:0]             command_byte,
  output logic signed [8:0]      target_workgroup
);

`include "esc_command_byte_parser_unit_defines.svh"

  logic [7:0] num_workgroups;
  logic       s1_valid;
  logic [7:0] s1_byte;
  escp_ctx_t  ctx;
  escp_ctx_t  ctx_next;
  escp_res_t  res;
  logic       advance;
  logic       cfg_write;

  // ---- configuration ----
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2:2] == REG_NUM_WG) ? {24'b0, num_workgroups} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_workgroups <= 8'd1;
    end else if (cfg_write && (paddr[2:2] == REG_NUM_WG)) begin
      num_workgroups <= pwdata[7:0];
    end
  end

  // ---- handshake ----
  // input register moves on whenever the result register is free or draining
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign byte_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_byte <= byte_in;
    end
  end

  // ---- parser step ----
  escp_step u_step (
    .ctx            (ctx),
    .byte_in        (s1_byte),
    .num_workgroups (num_workgroups),
    .ctx_next       (ctx_next),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= ST_IDLE;
      ctx.acc        <= '0;
      ctx.workgroup  <= WG_ALL;
      ctx.first_byte <= 8'd0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      part_of_command  <= res.part_of_command;
      command_done     <= res.command_done;
      command_byte     <= res.command_byte;
      target_workgroup <= res.target_workgroup;
    end
  end

  // ---- checks ----
  `ESCP_ASSERT_NOW(a_done_is_part, clk, rst, result_valid && command_done, part_of_command)
  `ESCP_ASSERT_NOW(a_no_event_zero, clk, rst, result_valid && !command_done, (command_byte == 8'd0) && (target_workgroup == 9'sd0))
  `ESCP_ASSERT_NEXT(a_ctx_holds, clk, rst, !advance, $stable(ctx))
  `ESCP_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_byte))

endmodule
`default_nettype wire
